// ===== hw/rtl/ddbenc_pkg.sv =====
// Shared types, constants and helpers for the distance-delay B-format encoder.
package ddbenc_pkg;

    // Default depth of the delay line and the number of output channels
    localparam int DEPTH_DEF = 4096;
    localparam int NUM_CH    = 4;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_WHOLE    = 3'd0,
        REG_DELAY_FRACTION = 3'd1,
        REG_INTERIOR_GAIN  = 3'd2,
        REG_EXTERIOR_GAIN  = 3'd3,
        REG_COEFF_W        = 3'd4,
        REG_COEFF_X        = 3'd5,
        REG_COEFF_Y        = 3'd6,
        REG_COEFF_Z        = 3'd7
    } cfg_idx_t;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MOD    = 10'b00_0000_0010,
        S_ADDR   = 10'b00_0000_0100,
        S_RDA    = 10'b00_0000_1000,
        S_RDB    = 10'b00_0001_0000,
        S_BLEND  = 10'b00_0010_0000,
        S_GAIN_I = 10'b00_0100_0000,
        S_GAIN_E = 10'b00_1000_0000,
        S_CHAN   = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    // Round a channel product (2^30 scale) to nearest and clamp to 16 signed bits
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [48:0] p);
        logic signed [49:0] pr;
        logic signed [19:0] v;
        logic [SAMPLE_W-1:0] r;
        pr = {p[48], p} + 50'sd536870912;
        v  = pr[49:30];
        if (v > 20'sd32767)
            r = 16'h7FFF;
        else if (v < -20'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/ddbenc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ddbenc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/distance_delay_bformat_encoder_core.sv =====
// Top level: delay line with fractional tap blend and four-channel B-format scaling.
//
//   port group   dir   contents
//   s_*          in    mono sample word, tlast = end of processing block
//   m_*          out   W/X/Y/Z channel word, tlast = copied block end
//   cfg_*        in    register write: index 0..7, data up to 16 bits
//
// Each word passes through these steps in order: a delay reduction, a tap address
// step, two reads of the single delay-line read port, a blend, two gain products,
// the channel steps that feed the shared coefficient multiplier and round its
// products, and the output load, which waits while an untaken word sits in the
// output register. s_tready returns in the next cycle, even if m_tready is low,
// so the next word is taken as soon as the result has moved into the output
// register. After reset a clearing pass writes zeros through all DEPTH entries
// before the first word is taken.
module distance_delay_bformat_encoder_core #(
    parameter int DEPTH = ddbenc_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side; tdata: sample_in[15:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ddbenc_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                            s_tlast,
    // master side; tdata: out_w[15:0], out_x[31:16], out_y[47:32], out_z[63:48]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [4*ddbenc_pkg::SAMPLE_W-1:0] m_tdata,
    output logic                            m_tlast,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ddbenc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ddbenc_pkg::CFG_W-1:0]    cfg_data
);

    import ddbenc_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int RK    = 24;                    // reciprocal scale
    localparam int RM    = (1 << RK) / DEPTH;     // floor(2^RK / DEPTH)
    localparam int PW    = DELAY_W + RK;          // delay * reciprocal width
    localparam int QW    = DELAY_W + AW + 1;      // quotient * depth width
    localparam int CHW   = $clog2(NUM_CH + 1);
    localparam logic [RK-1:0]   RECIP   = RK'(RM);
    localparam logic [QW-1:0]   DEPTH_Q = QW'(DEPTH);
    localparam logic [AW:0]     DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]   LAST_A  = AW'(DEPTH - 1);
    localparam logic [CHW-1:0]  CH_END  = CHW'(NUM_CH);

    // Configuration registers
    logic [DELAY_W-1:0]  delay_reg;
    logic [CFG_W-1:0]    frac_reg;
    logic [CFG_W-1:0]    gain_i_reg;
    logic [CFG_W-1:0]    gain_e_reg;
    logic [CFG_W-1:0]    coeff_w_reg;
    logic [CFG_W-1:0]    coeff_x_reg;
    logic [CFG_W-1:0]    coeff_y_reg;
    logic [CFG_W-1:0]    coeff_z_reg;

    // Control state
    state_t              state_reg, state_next;
    logic                clr_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       wp_reg;
    logic [CHW-1:0]      ch_reg;
    logic                m_valid_reg;

    // Payload registers
    logic [AW-1:0]       wp_item_reg;
    logic                last_reg;
    logic [PW-1:0]       prod_reg;
    logic [AW-1:0]       d_reg;
    logic [AW-1:0]       ia_reg;
    logic [AW-1:0]       ib_reg;
    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] s_reg;
    logic signed [32:0]  t_i_reg;
    logic signed [32:0]  t_e_reg;
    logic signed [48:0]  p_reg;
    logic [NUM_CH-1:0][SAMPLE_W-1:0] res_reg;
    logic [4*SAMPLE_W-1:0] m_data_reg;
    logic                m_last_reg;

    // Combinational signals
    logic                accept;
    logic                out_load;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [DELAY_W-1:0]  quot;
    logic [QW-1:0]       rem_raw;
    logic [AW:0]         tap_diff;
    logic [AW:0]         tap_a;
    logic [AW:0]         tap_b;
    logic signed [16:0]  diff_ab;
    logic signed [33:0]  mix;
    logic signed [34:0]  blend;
    logic signed [32:0]  t_sel;
    logic [CFG_W-1:0]    coeff_sel;
    logic [1:0]          res_idx;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !clr_reg;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= '0;
            frac_reg    <= '0;
            gain_i_reg  <= '0;
            gain_e_reg  <= '0;
            coeff_w_reg <= '0;
            coeff_x_reg <= '0;
            coeff_y_reg <= '0;
            coeff_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_DELAY_WHOLE:    delay_reg   <= cfg_data[DELAY_W-1:0];
                REG_DELAY_FRACTION: frac_reg    <= cfg_data;
                REG_INTERIOR_GAIN:  gain_i_reg  <= cfg_data;
                REG_EXTERIOR_GAIN:  gain_e_reg  <= cfg_data;
                REG_COEFF_W:        coeff_w_reg <= cfg_data;
                REG_COEFF_X:        coeff_x_reg <= cfg_data;
                REG_COEFF_Y:        coeff_y_reg <= cfg_data;
                REG_COEFF_Z:        coeff_z_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Sequence one word through the steps
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_MOD;
            S_MOD:    state_next = S_ADDR;
            S_ADDR:   state_next = S_RDA;
            S_RDA:    state_next = S_RDB;
            S_RDB:    state_next = S_BLEND;
            S_BLEND:  state_next = S_GAIN_I;
            S_GAIN_I: state_next = S_GAIN_E;
            S_GAIN_E: state_next = S_CHAN;
            S_CHAN:   if (ch_reg == CH_END) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers: state, clearing pass, write position, channel count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            ch_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_A)
                begin
                    clr_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                wp_reg <= (wp_reg == LAST_A) ? '0 : wp_reg + AW'(1);
            end

            if (state_reg == S_CHAN)
            begin
                ch_reg <= (ch_reg == CH_END) ? '0 : ch_reg + CHW'(1);
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Delay line: clearing pass writes zeros, otherwise the accepted sample
    assign ram_we    = clr_reg || accept;
    assign ram_waddr = clr_reg ? clr_addr_reg : wp_reg;
    assign ram_wdata = clr_reg ? '0 : s_tdata;
    assign ram_raddr = (state_reg == S_RDB) ? ib_reg : ia_reg;

    ddbenc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Reduce the delay modulo DEPTH: reciprocal quotient, one correction
    assign quot    = prod_reg[PW-1:RK];
    assign rem_raw = QW'(delay_reg) - QW'(quot) * DEPTH_Q;

    // Tap addresses: A at (write - delay), B one entry newer
    assign tap_diff = {1'b0, wp_item_reg} - {1'b0, d_reg};
    assign tap_a    = tap_diff[AW] ? tap_diff + DEPTH_A : tap_diff;
    assign tap_b    = (ia_reg == LAST_A) ? '0 : {1'b0, ia_reg} + (AW + 1)'(1);

    // Blend: a + (b - a) * f, rounded at 2^16
    assign diff_ab = $signed({ram_rdata[15], ram_rdata}) - $signed({a_reg[15], a_reg});
    assign mix     = diff_ab * $signed({1'b0, frac_reg});
    assign blend   = $signed({{3{a_reg[15]}}, a_reg, 16'h0000}) + $signed({mix[33], mix})
                   + 35'sd32768;

    // Select gain product and coefficient for the current channel
    assign t_sel   = (ch_reg == '0) ? t_i_reg : t_e_reg;
    assign res_idx = 2'(ch_reg - CHW'(1));
    always_comb
    begin
        case (ch_reg[1:0])
            2'd0:    coeff_sel = coeff_w_reg;
            2'd1:    coeff_sel = coeff_x_reg;
            2'd2:    coeff_sel = coeff_y_reg;
            2'd3:    coeff_sel = coeff_z_reg;
            default: coeff_sel = coeff_w_reg;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wp_item_reg <= wp_reg;
            last_reg    <= s_tlast;
            prod_reg    <= PW'(delay_reg) * PW'(RECIP);
        end

        if (state_reg == S_MOD)
        begin
            d_reg <= (rem_raw >= DEPTH_Q) ? AW'(rem_raw - DEPTH_Q) : AW'(rem_raw);
        end

        if (state_reg == S_ADDR)
        begin
            ia_reg <= tap_a[AW-1:0];
        end

        if (state_reg == S_RDA)
        begin
            ib_reg <= tap_b[AW-1:0];
        end

        if (state_reg == S_RDB)
        begin
            a_reg <= ram_rdata;
        end

        if (state_reg == S_BLEND)
        begin
            s_reg <= blend[31:16];
        end

        if (state_reg == S_GAIN_I)
        begin
            t_i_reg <= $signed(s_reg) * $signed({1'b0, gain_i_reg});
        end

        if (state_reg == S_GAIN_E)
        begin
            t_e_reg <= $signed(s_reg) * $signed({1'b0, gain_e_reg});
        end

        // Multiply one channel and round the previous one
        if (state_reg == S_CHAN)
        begin
            if (ch_reg != CH_END)
            begin
                p_reg <= t_sel * $signed(coeff_sel);
            end
            if (ch_reg != '0)
            begin
                res_reg[res_idx] <= round_sat(p_reg);
            end
        end

        if (out_load)
        begin
            m_data_reg <= res_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/tb_distance_delay_bformat_encoder_core.sv =====
// Testbench for the distance-delay B-format encoder core: streamed samples checked by a predictor.
module tb_distance_delay_bformat_encoder_core;
    import ddbenc_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_WORDS   = 150;

    // One channel word as it leaves the block: w in the lowest bits, block end on top
    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] z;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] w;
    } chan_word_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        cfg_idx_t            idx;
        logic [CFG_W-1:0]    value;
        logic                last;
        bit                  typed;
        chan_word_t          want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SAMPLE_W-1:0]     s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [4*SAMPLE_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]        cfg_data;

    // Predictor state: delay line, write head and register copies
    logic [SAMPLE_W-1:0]     line_mem [STORE_DEPTH];
    logic [DELAY_W-1:0]      head;
    logic [DELAY_W-1:0]      dly_whole;
    logic [CFG_W-1:0]        dly_frac;
    logic [CFG_W-1:0]        gain_in;
    logic [CFG_W-1:0]        gain_out;
    logic [CFG_W-1:0]        coef_w;
    logic [CFG_W-1:0]        coef_x;
    logic [CFG_W-1:0]        coef_y;
    logic [CFG_W-1:0]        coef_z;

    chan_word_t              pending_words[$];
    plan_row_t               plan[$];

    int                      errors;
    int                      words_sent;
    int                      words_checked;
    int                      reg_writes;
    int                      rx_hold;
    bit                      calm;
    bit                      tx_busy;
    bit                      rx_busy;

    distance_delay_bformat_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Scale the blended sample by gain and coefficient, round once, clamp to 16 bits
    function automatic logic [SAMPLE_W-1:0] scale_chan(input longint mix, input longint gain,
                                                       input logic [CFG_W-1:0] coef);
        longint p;
        p = (mix * gain * longint'($signed(coef)) + 64'sd536870912) >>> 30;
        if (p > 32767)
            return 16'h7FFF;
        if (p < -32768)
            return 16'h8000;
        return p[SAMPLE_W-1:0];
    endfunction

    // Write the sample, blend the two taps, form the four channels, advance the head
    function automatic chan_word_t encode_sample(input logic [SAMPLE_W-1:0] smp,
                                                 input logic lst);
        logic [DELAY_W-1:0] tap_a;
        logic [DELAY_W-1:0] tap_b;
        longint             a;
        longint             b;
        longint             fr;
        longint             mix;
        chan_word_t         r;
        line_mem[head] = smp;
        tap_a = head - dly_whole;
        tap_b = tap_a + 1'b1;
        a = $signed(line_mem[tap_a]);
        b = $signed(line_mem[tap_b]);
        fr = dly_frac;
        mix = (a * (65536 - fr) + b * fr + 64'sd32768) >>> 16;
        r.w = scale_chan(mix, gain_in, coef_w);
        r.x = scale_chan(mix, gain_out, coef_x);
        r.y = scale_chan(mix, gain_out, coef_y);
        r.z = scale_chan(mix, gain_out, coef_z);
        r.last = lst;
        head = head + 1'b1;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = {{12{v[15]}}, v[3:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        plan_row_t row;
        row = '{ROW_REG, idx, value, 1'b0, 1'b0, '0};
        plan.push_back(row);
    endfunction

    function automatic void add_word(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                     input bit typed, input logic [SAMPLE_W-1:0] w,
                                     input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                                     input logic [SAMPLE_W-1:0] z);
        plan_row_t row;
        row = '{ROW_WORD, REG_DELAY_WHOLE, smp, lst, typed, '{lst, z, y, x, w}};
        plan.push_back(row);
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_addr <= idx;
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_DELAY_WHOLE:    dly_whole = value[DELAY_W-1:0];
            REG_DELAY_FRACTION: dly_frac  = value;
            REG_INTERIOR_GAIN:  gain_in   = value;
            REG_EXTERIOR_GAIN:  gain_out  = value;
            REG_COEFF_W:        coef_w    = value;
            REG_COEFF_X:        coef_x    = value;
            REG_COEFF_Y:        coef_y    = value;
            REG_COEFF_Z:        coef_z    = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Drop the stream and hold until every expected word has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Offer one sample word, hold it until taken, then queue its expected channels
    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic lst,
                             input bit typed, input chan_word_t want);
        chan_word_t pred;
        int         gap;
        gap = 0;
        if (!calm && tx_busy && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        pred = encode_sample(smp, lst);
        pending_words.push_back(typed ? want : pred);
        words_sent++;
    endtask

    // Pick a fresh setting for every register, leaning toward the extremes
    task automatic program_random();
        logic [CFG_W-1:0] v;
        int               sel;
        cfg_idx_t         gain_regs[2];
        cfg_idx_t         coef_regs[4];
        gain_regs = '{REG_INTERIOR_GAIN, REG_EXTERIOR_GAIN};
        coef_regs = '{REG_COEFF_W, REG_COEFF_X, REG_COEFF_Y, REG_COEFF_Z};
        // delay: upper data bits random, mostly short delays so taps see written data
        v = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v[11:4] = 8'h00;
        else if (sel < 7)
            v[11:4] = 8'hFF;
        write_reg(REG_DELAY_WHOLE, v);
        v = 16'($urandom);
        case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h8000;
            default: ;
        endcase
        write_reg(REG_DELAY_FRACTION, v);
        foreach (gain_regs[i])
        begin
            sel = $urandom_range(0, 19);
            if (sel < 12)
                v = 16'($urandom_range(0, 32768));
            else if (sel < 15)
                v = 16'h8000;
            else if (sel < 17)
                v = 16'h0000;
            else
                v = 16'($urandom);
            write_reg(gain_regs[i], v);
        end
        foreach (coef_regs[i])
        begin
            v = 16'($urandom);
            case ($urandom_range(0, 5))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                default: ;
            endcase
            write_reg(coef_regs[i], v);
        end
    endtask

    // Receiver: ready with random stall bursts, none once the run calms down
    initial
    begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (!calm && rx_busy && $urandom_range(0, 7) == 0)
            begin
                rx_hold = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare every taken channel word with the oldest expectation
    initial
    begin
        chan_word_t got;
        chan_word_t want;
        bit         bad;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = {m_tlast, m_tdata};
                if (pending_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: w=%h x=%h y=%h z=%h last=%b",
                                 got.w, got.x, got.y, got.z, got.last);
                end
                else
                begin
                    want = pending_words.pop_front();
                    bad = 1'b0;
                    for (int ch = 0; ch < NUM_CH; ch++)
                        if (got[SAMPLE_W*ch +: SAMPLE_W] !== want[SAMPLE_W*ch +: SAMPLE_W])
                            bad = 1'b1;
                    if (got.last !== want.last)
                        bad = 1'b1;
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("word %0d: want w=%h x=%h y=%h z=%h last=%b",
                                     words_checked, want.w, want.x, want.y, want.z,
                                     want.last);
                            $display("word %0d: got  w=%h x=%h y=%h z=%h last=%b",
                                     words_checked, got.w, got.x, got.y, got.z, got.last);
                        end
                    end
                    words_checked++;
                end
            end
        end
    end

    // Hard stop for a hung run
    initial
    begin
        #6000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int          random_sent;
        int          phase_len;
        int          blen;
        logic        lst;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = REG_DELAY_WHOLE;
        cfg_data = '0;
        calm     = 1'b0;
        tx_busy  = 1'b1;
        rx_busy  = 1'b1;
        errors   = 0;
        words_sent    = 0;
        words_checked = 0;
        reg_writes    = 0;
        random_sent   = 0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        head      = '0;
        dly_whole = '0;
        dly_frac  = '0;
        gain_in   = '0;
        gain_out  = '0;
        coef_w    = '0;
        coef_x    = '0;
        coef_y    = '0;
        coef_z    = '0;

        // after reset every register is zero, so all channels are silent
        add_word(16'h7FFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_word(16'h8000, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // unity gains, coefficients from full scale down to zero, no delay: channels scale the input
        add_reg(REG_DELAY_WHOLE,    16'h0000);
        add_reg(REG_DELAY_FRACTION, 16'h0000);
        add_reg(REG_INTERIOR_GAIN,  16'h8000);
        add_reg(REG_EXTERIOR_GAIN,  16'h8000);
        add_reg(REG_COEFF_W,        16'h7FFF);
        add_reg(REG_COEFF_X,        16'h8000);
        add_reg(REG_COEFF_Y,        16'h4000);
        add_reg(REG_COEFF_Z,        16'h0000);
        add_word(16'h7FFF, 1'b0, 1'b1, 16'h7FFE, 16'h8001, 16'h4000, 16'h0000);
        add_word(16'h8000, 1'b1, 1'b1, 16'h8001, 16'h7FFF, 16'hC000, 16'h0000);
        add_word(16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_word(16'h0001, 1'b1, 1'b1, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000);
        // zero delay with half fraction: newest sample blended with the oldest entry
        add_reg(REG_DELAY_FRACTION, 16'h8000);
        add_word(16'h1234, 1'b0, 1'b0, '0, '0, '0, '0);
        add_word(16'h8000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_word(16'h7FFF, 1'b1, 1'b0, '0, '0, '0, '0);
        // delay keeps only its low 12 bits; gains above unity drive saturation
        add_reg(REG_DELAY_WHOLE,    16'hF001);
        add_reg(REG_DELAY_FRACTION, 16'hFFFF);
        add_reg(REG_INTERIOR_GAIN,  16'hFFFF);
        add_reg(REG_EXTERIOR_GAIN,  16'hFFFF);
        add_reg(REG_COEFF_W,        16'h8000);
        add_reg(REG_COEFF_X,        16'h7FFF);
        add_reg(REG_COEFF_Y,        16'h0001);
        add_reg(REG_COEFF_Z,        16'hFFFF);
        add_word(16'h7FFF, 1'b0, 1'b0, '0, '0, '0, '0);
        add_word(16'h8000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_word(16'h4000, 1'b1, 1'b0, '0, '0, '0, '0);
        add_word(16'hC000, 1'b0, 1'b0, '0, '0, '0, '0);
        // longest delay: taps wrap onto the oldest entries
        add_reg(REG_DELAY_WHOLE,    16'h0FFF);
        add_reg(REG_DELAY_FRACTION, 16'h0001);
        add_reg(REG_INTERIOR_GAIN,  16'h0000);
        add_reg(REG_EXTERIOR_GAIN,  16'h8000);
        add_reg(REG_COEFF_Z,        16'h7FFF);
        add_word(16'h5555, 1'b0, 1'b0, '0, '0, '0, '0);
        add_word(16'hAAAA, 1'b1, 1'b0, '0, '0, '0, '0);
        add_word(16'h7FFF, 1'b0, 1'b0, '0, '0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: registers only while the block is drained
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
                send_word(plan[i].value, plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random phases: new setting, then blocks of samples with periodic block ends
        while (random_sent < RANDOM_WORDS)
        begin
            wait_idle();
            program_random();
            calm = (RANDOM_WORDS - random_sent) <= CALM_WORDS;
            phase_len = calm ? RANDOM_WORDS - random_sent : $urandom_range(20, 150);
            blen = $urandom_range(1, 32);
            tx_busy = $urandom_range(0, 2) != 0;
            rx_busy = $urandom_range(0, 2) != 0;
            for (int n = 0; n < phase_len && random_sent < RANDOM_WORDS; n++)
            begin
                lst = (n % blen) == blen - 1;
                if ($urandom_range(0, 9) == 0)
                    lst = 1'($urandom_range(0, 1));
                send_word(pick_sample(), lst, 1'b0, '0);
                random_sent++;
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);

        $display("Checked %0d channel words from %0d samples across %0d register writes",
                 words_checked, words_sent, reg_writes);
        $display("Covered zero to full-length delays, fraction extremes and saturating gains");
        if (errors == 0 && pending_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
